### rtl/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg - shared types and constants for the three-value GCD reducer
// Field widths, stream packing, controller command and status bundles.
// ----------------------------------------------------------------------------
package gtr_pkg;

	// width of every value field
	localparam int DW = 31;

	// stream widths, fields packed from bit 0 and padded to whole bytes
	localparam int S_TDATA_W = ((3 * DW + 7) / 8) * 8;
	localparam int M_TDATA_W = ((4 * DW + 7) / 8) * 8;

	// divider step counter holds 0..DW
	localparam int CNT_W = $clog2(DW + 1);

	// divider operand / writeback selection
	typedef enum logic [1:0] {
		SEL_EUC,
		SEL_A,
		SEL_B,
		SEL_C
	} sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // capture input beat, x = b, y = c
		logic div_start;  // launch divider on selected operands
		logic wb;         // write divider result back per sel
		logic euc_next;   // second Euclid pass: x = a, y = x
		logic out_load;   // copy result into output register
		sel_t sel;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic y_zero;
		logic g_gt1;
		logic div_done;
	} sts_t;

endpackage

### rtl/gcd_three_reduce.sv
// ----------------------------------------------------------------------------
// gcd_three_reduce - reduce three counts by their greatest common divisor
// g = gcd(a, gcd(b, c)) by Euclid's remainder loop; a, b, c divided by g
// when g exceeds one.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_*      in   value_a, value_b, value_c
//  m_*      out  divisor, reduced_a, reduced_b, reduced_c
//
// Each remainder or quotient comes from the one shared restoring
// divider (DW = 31).
// One item in flight; s_tready is high only while the sequencer is idle.
// The result waits in the output register; a stalled m_tready holds the
// sequencer in its last state only while the previous result is unread.
// Reset clears control state only.
// ----------------------------------------------------------------------------
module gcd_three_reduce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// value_a, value_b, value_c, zero pad
	input  logic [gtr_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// divisor, reduced_a, reduced_b, reduced_c, zero pad
	output logic [gtr_pkg::M_TDATA_W-1:0] m_tdata
);
	import gtr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gtr_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.out_data (m_tdata)
	);

endmodule

### rtl/gtr_divider.sv
// ----------------------------------------------------------------------------
// gtr_divider - restoring radix-2 divider
// One quotient bit per cycle, DW quotient bits per division, done pulses once.
// ----------------------------------------------------------------------------
module gtr_divider (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [gtr_pkg::DW-1:0] dividend,
	input  logic [gtr_pkg::DW-1:0] divisor,
	output logic                   done,
	output logic [gtr_pkg::DW-1:0] quotient,
	output logic [gtr_pkg::DW-1:0] remainder
);
	import gtr_pkg::*;

	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW+1:0]    diff;

	// trial subtract of the shifted partial remainder
	always_comb begin
		diff = {1'b0, rem_q, quo_q[DW-1]} - {2'b00, den_q};
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	// step count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/gtr_datapath.sv
// ----------------------------------------------------------------------------
// gtr_datapath - operand registers, Euclid pair, shared divider, output regs
// Acts only on controller commands; reports zero / greater-than-one / done.
// ----------------------------------------------------------------------------
module gtr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gtr_pkg::cmd_t                 cmd,
	output gtr_pkg::sts_t                 sts,
	input  logic [gtr_pkg::S_TDATA_W-1:0] in_data,
	output logic [gtr_pkg::M_TDATA_W-1:0] out_data
);
	import gtr_pkg::*;

	logic [DW-1:0] a_q, b_q, c_q;
	logic [DW-1:0] x_q, y_q;
	logic [DW-1:0] divisor_q, red_a_q, red_b_q, red_c_q;
	logic [DW-1:0] dvd, dvs;
	logic [DW-1:0] quo, rem;
	logic          div_done;

	// divider operand select
	always_comb begin
		case (cmd.sel)
			SEL_A:   begin dvd = a_q; dvs = x_q; end
			SEL_B:   begin dvd = b_q; dvs = x_q; end
			SEL_C:   begin dvd = c_q; dvs = x_q; end
			default: begin dvd = x_q; dvs = y_q; end
		endcase
	end

	gtr_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dvd),
		.divisor   (dvs),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	// operand and Euclid registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= in_data[DW-1:0];
			b_q <= in_data[2*DW-1:DW];
			c_q <= in_data[3*DW-1:2*DW];
			x_q <= in_data[2*DW-1:DW];
			y_q <= in_data[3*DW-1:2*DW];
		end else if (cmd.euc_next) begin
			x_q <= a_q;
			y_q <= x_q;
		end else if (cmd.wb) begin
			case (cmd.sel)
				SEL_A:   a_q <= quo;
				SEL_B:   b_q <= quo;
				SEL_C:   c_q <= quo;
				default: begin
					x_q <= y_q;
					y_q <= rem;
				end
			endcase
		end
	end

	// output register, held until the beat is taken
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			divisor_q <= x_q;
			red_a_q   <= a_q;
			red_b_q   <= b_q;
			red_c_q   <= c_q;
		end
	end

	assign out_data = {{(M_TDATA_W - 4 * DW){1'b0}}, red_c_q, red_b_q, red_a_q, divisor_q};

	assign sts.y_zero   = (y_q == '0);
	assign sts.g_gt1    = (x_q > DW'(1));
	assign sts.div_done = div_done;

endmodule

### rtl/gtr_ctrl.sv
// ----------------------------------------------------------------------------
// gtr_ctrl - sequencer for the reducer
// Two Euclid passes, up to three reducing divisions, then the output beat.
// ----------------------------------------------------------------------------
module gtr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  gtr_pkg::sts_t sts,
	output gtr_pkg::cmd_t cmd
);
	import gtr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUC1,
		ST_WAIT1,
		ST_EUC2,
		ST_WAIT2,
		ST_RED,
		ST_WRED,
		ST_FIN
	} state_t;

	state_t state_q;
	sel_t   red_sel_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// command decode
	always_comb begin
		cmd = '0;
		cmd.sel = SEL_EUC;
		unique case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_EUC1: begin
				cmd.euc_next  = sts.y_zero;
				cmd.div_start = !sts.y_zero;
			end
			ST_WAIT1: cmd.wb = sts.div_done;
			ST_EUC2:  cmd.div_start = !sts.y_zero;
			ST_WAIT2: cmd.wb = sts.div_done;
			ST_RED: begin
				cmd.sel       = red_sel_q;
				cmd.div_start = 1'b1;
			end
			ST_WRED: begin
				cmd.sel = red_sel_q;
				cmd.wb  = sts.div_done;
			end
			ST_FIN:   cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			red_sel_q   <= SEL_A;
			out_valid_q <= 1'b0;
		end else begin
			// old beat taken with no new result loaded behind it
			if (out_valid_q && out_ready && !cmd.out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EUC1;
				end
				ST_EUC1: begin
					state_q <= sts.y_zero ? ST_EUC2 : ST_WAIT1;
				end
				ST_WAIT1: begin
					if (sts.div_done) state_q <= ST_EUC1;
				end
				ST_EUC2: begin
					if (!sts.y_zero) begin
						state_q <= ST_WAIT2;
					end else if (sts.g_gt1) begin
						red_sel_q <= SEL_A;
						state_q   <= ST_RED;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_WAIT2: begin
					if (sts.div_done) state_q <= ST_EUC2;
				end
				ST_RED: state_q <= ST_WRED;
				ST_WRED: begin
					if (sts.div_done) begin
						case (red_sel_q)
							SEL_A:   begin red_sel_q <= SEL_B; state_q <= ST_RED; end
							SEL_B:   begin red_sel_q <= SEL_C; state_q <= ST_RED; end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
